/* hw/rtl/lsfrd_pkg.sv */
// shared types and constants for the scan sample frame decoder
package lsfrd_pkg;

  // bytes held in the window before the fifth one arrives
  localparam int unsigned HeldMax = 4;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned FillW   = 3;
  localparam int unsigned QualW   = 6;
  localparam int unsigned AngleW  = 15;
  localparam int unsigned DistW   = 16;
  localparam int unsigned CountW  = 32;

  // bit positions checked in the header bytes
  localparam int unsigned StartBit    = 0;
  localparam int unsigned InvStartBit = 1;
  localparam int unsigned CheckBit    = 0;

  // result status codes
  localparam logic StatusSample = 1'b0;
  localparam logic StatusResync = 1'b1;

  typedef logic [ByteW-1:0]  byte_t;
  typedef logic [FillW-1:0]  fill_t;
  typedef logic [CountW-1:0] count_t;

  // one decoded result
  typedef struct packed {
    logic              status;
    logic              rev_start;
    logic [QualW-1:0]  quality;
    logic [AngleW-1:0] angle_code;
    logic [DistW-1:0]  dist_code;
    count_t            good_frames;
    count_t            bad_windows;
  } sample_t;

endpackage

/* hw/rtl/lidar_sample_frame_resync_decoder_core.sv */
// top level of the five byte scan sample frame decoder
//
//   channel  | handshake                  | payload
//   ---------+----------------------------+--------------------------------
//   input    | in_valid_i / in_ready_o    | rx_byte_i
//   output   | out_valid_o / out_ready_i  | status_o .. bad_windows_o
//
// one byte per cycle sustained while results are taken; a result shows on the
// output once its fifth byte has passed the input register, then the result register
// bytes that only fill the window give no result and never stall
// the input stage stalls only while it holds a window-completing byte and
// the result register is full and not being taken
// reset empties the window and clears both counters at once, no sweep
module lidar_sample_frame_resync_decoder_core
  import lsfrd_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [ByteW-1:0]         rx_byte_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic                     status_o,
  output logic                     rev_start_o,
  output logic [QualW-1:0]         quality_o,
  output logic [AngleW-1:0]        angle_code_o,
  output logic [DistW-1:0]         dist_code_o,
  output logic [CountW-1:0]        good_frames_o,
  output logic [CountW-1:0]        bad_windows_o
);

  logic    s1_valid_q;
  byte_t   s1_byte_q;
  logic    s1_go;
  logic    has_result;
  logic    res_free;
  sample_t result;
  sample_t out_data;

  // stage 1 moves on unless its result has nowhere to go
  assign s1_go      = s1_valid_q && (!has_result || res_free);
  assign in_ready_o = !s1_valid_q || s1_go;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_byte_q <= rx_byte_i;
    end
  end

  lsfrd_frame_check u_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .byte_i       (s1_byte_q),
    .fire_i       (s1_go),
    .has_result_o (has_result),
    .result_o     (result)
  );

  lsfrd_result_reg u_result (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (s1_go && has_result),
    .data_i  (result),
    .free_o  (res_free),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .data_o  (out_data)
  );

  // result fields to ports
  assign status_o      = out_data.status;
  assign rev_start_o   = out_data.rev_start;
  assign quality_o     = out_data.quality;
  assign angle_code_o  = out_data.angle_code;
  assign dist_code_o   = out_data.dist_code;
  assign good_frames_o = out_data.good_frames;
  assign bad_windows_o = out_data.bad_windows;

endmodule

/* hw/rtl/lsfrd_frame_check.sv */
// byte window, frame check, field decode and running counters
module lsfrd_frame_check
  import lsfrd_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  byte_t   byte_i,
  input  logic    fire_i,
  output logic    has_result_o,
  output sample_t result_o
);

  byte_t  window_q [HeldMax];
  fill_t  fill_q;
  count_t good_q;
  count_t bad_q;

  logic   full;
  logic   pass;
  count_t good_inc;
  count_t bad_inc;

  // header check on the first two of the four held bytes
  assign full     = fill_q[FillW-1];
  assign pass     = (window_q[0][StartBit] ^ window_q[0][InvStartBit]) & window_q[1][CheckBit];
  assign good_inc = good_q + count_t'(1);
  assign bad_inc  = bad_q + count_t'(1);

  assign has_result_o = full;

  // result fields; a rejected window sets only status and the counters, the rest zero
  always_comb begin
    result_o = '0;
    if (pass) begin
      result_o.status      = StatusSample;
      result_o.rev_start   = window_q[0][StartBit];
      result_o.quality     = window_q[0][ByteW-1:2];
      result_o.angle_code  = {window_q[2], window_q[1][ByteW-1:1]};
      result_o.dist_code   = {byte_i, window_q[3]};
      result_o.good_frames = good_inc;
      result_o.bad_windows = bad_q;
    end else begin
      result_o.status      = StatusResync;
      result_o.good_frames = good_q;
      result_o.bad_windows = bad_inc;
    end
  end

  // window fill, shift on reject, clear on a good frame
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < HeldMax; i++) begin
        window_q[i] <= '0;
      end
      fill_q <= '0;
      good_q <= '0;
      bad_q  <= '0;
    end else if (fire_i) begin
      if (!full) begin
        window_q[fill_q[1:0]] <= byte_i;
        fill_q                <= fill_q + fill_t'(1);
      end else if (pass) begin
        fill_q <= '0;
        good_q <= good_inc;
      end else begin
        for (int i = 0; i < HeldMax - 1; i++) begin
          window_q[i] <= window_q[i+1];
        end
        window_q[HeldMax-1] <= byte_i;
        fill_q              <= fill_t'(HeldMax);
        bad_q               <= bad_inc;
      end
    end
  end

`ifndef SYNTHESIS
  a_fill_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= fill_t'(HeldMax))
    else $error("fill level above window depth");

  a_fill_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && !full |=> fill_q == $past(fill_q) + fill_t'(1) && good_q == $past(good_q))
    else $error("partial window did not just grow");

  a_good_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && full && pass |=> fill_q == '0 && good_q == $past(good_q) + count_t'(1))
    else $error("good frame did not empty window or count");

  a_bad_shift: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && full && !pass |=> fill_q == fill_t'(HeldMax) && bad_q == $past(bad_q) + count_t'(1)
      && window_q[HeldMax-1] == $past(byte_i))
    else $error("rejected window not shifted or counted");

  a_idle_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !fire_i |=> $stable(fill_q) && $stable(good_q) && $stable(bad_q))
    else $error("state moved without a transaction");
`endif

endmodule

/* hw/rtl/lsfrd_result_reg.sv */
// output register holding one decoded result until taken
module lsfrd_result_reg
  import lsfrd_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    load_i,
  input  sample_t data_i,
  output logic    free_o,
  output logic    valid_o,
  input  logic    ready_i,
  output sample_t data_o
);

  logic    valid_q;
  sample_t data_q;

  // register can take a new result when empty or being drained
  assign free_o  = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (free_o) begin
      valid_q <= load_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (free_o && load_i) begin
      data_q <= data_i;
    end
  end

endmodule

/* bench/lidar_sample_frame_resync_decoder_core_tb.sv */
`timescale 1ns / 100ps
// self-checking bench for the five byte scan sample frame decoder core
module lidar_sample_frame_resync_decoder_core_tb;
  import lsfrd_pkg::*;

  localparam int unsigned StallLimit = 2000;
  localparam int unsigned HoldLen    = 150;
  localparam int unsigned PhaseBytes = 544;
  localparam int unsigned MaxReports = 10;

  // directed bytes: widest frame, narrowest frame, then windows failing each header check
  localparam byte_t Directed [18] = '{
    8'hFD, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
    8'h02, 8'h01, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h03, 8'h02, 8'hFE, 8'h10, 8'h20, 8'h40, 8'h80
  };

  // tracks the byte window and counters, queues the samples each byte should produce
  class frame_decode_sb;
    byte_t       held [HeldMax];
    fill_t       fill;
    count_t      good_total;
    count_t      bad_total;
    sample_t     samples_due [$];
    int unsigned mismatches;

    function void clear();
      foreach (held[i]) held[i] = '0;
      fill = '0;
      good_total = '0;
      bad_total = '0;
      mismatches = 0;
      samples_due.delete();
    endfunction

    // accepted input byte transaction
    function void take_byte(byte_t b);
      sample_t r;
      if (fill < HeldMax) begin
        held[fill[1:0]] = b;
        fill = fill + 1'b1;
        return;
      end
      r = '0;
      if ((held[0][StartBit] != held[0][InvStartBit]) && held[1][CheckBit]) begin
        // header good: decode and empty the window
        good_total = good_total + 1'b1;
        fill = '0;
        r.status = StatusSample;
        r.rev_start = held[0][StartBit];
        r.quality = held[0][ByteW-1:2];
        r.angle_code = {held[2], held[1][ByteW-1:1]};
        r.dist_code = {b, held[3]};
      end else begin
        // header bad: drop oldest byte, keep four newest
        for (int i = 0; i < HeldMax - 1; i++) held[i] = held[i+1];
        held[HeldMax-1] = b;
        bad_total = bad_total + 1'b1;
        r.status = StatusResync;
      end
      r.good_frames = good_total;
      r.bad_windows = bad_total;
      samples_due.push_back(r);
    endfunction

    function void report(string what, sample_t want, sample_t got);
      mismatches++;
      if (mismatches <= MaxReports) begin
        $display("%0t %s", $time, what);
        $display("  exp st=%0d sf=%0d q=%0d ang=%0d dist=%0d good=%0d bad=%0d",
                 want.status, want.rev_start, want.quality, want.angle_code,
                 want.dist_code, want.good_frames, want.bad_windows);
        $display("  got st=%0d sf=%0d q=%0d ang=%0d dist=%0d good=%0d bad=%0d",
                 got.status, got.rev_start, got.quality, got.angle_code,
                 got.dist_code, got.good_frames, got.bad_windows);
      end
    endfunction

    // accepted result transaction
    function void check_sample(sample_t got);
      sample_t want;
      bit      wrong;
      if (samples_due.size() == 0) begin
        report("result with nothing expected", '0, got);
        return;
      end
      want = samples_due.pop_front();
      wrong = (got.status !== want.status) || (got.rev_start !== want.rev_start) ||
              (got.quality !== want.quality) || (got.angle_code !== want.angle_code) ||
              (got.dist_code !== want.dist_code) ||
              (got.good_frames !== want.good_frames) ||
              (got.bad_windows !== want.bad_windows);
      if (wrong) report("result field mismatch", want, got);
    endfunction
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  logic [ByteW-1:0]   rx_byte_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic               status_o;
  logic               rev_start_o;
  logic [QualW-1:0]   quality_o;
  logic [AngleW-1:0]  angle_code_o;
  logic [DistW-1:0]   dist_code_o;
  logic [CountW-1:0]  good_frames_o;
  logic [CountW-1:0]  bad_windows_o;

  frame_decode_sb sb;
  sample_t        seen;
  int unsigned    send_idle_pct;
  int unsigned    recv_idle_pct;
  bit             hold_req;

  lidar_sample_frame_resync_decoder_core u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .rx_byte_i     (rx_byte_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .status_o      (status_o),
    .rev_start_o   (rev_start_o),
    .quality_o     (quality_o),
    .angle_code_o  (angle_code_o),
    .dist_code_o   (dist_code_o),
    .good_frames_o (good_frames_o),
    .bad_windows_o (bad_windows_o)
  );

  // 2 ns clock
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // offer one byte with random idle in front, return at the falling edge after acceptance
  task automatic send_byte(input byte_t b);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    rx_byte_i = b;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.take_byte(b);
    @(negedge clk_i);
  endtask

  // five bytes with a valid header, or with one header check broken
  task automatic send_frame(input bit broken);
    byte_t f [5];
    foreach (f[i]) f[i] = byte_t'($urandom);
    f[0][InvStartBit] = ~f[0][StartBit];
    f[1][CheckBit] = 1'b1;
    if (broken) begin
      if ($urandom_range(0, 1) != 0) f[0][InvStartBit] = f[0][StartBit];
      else f[1][CheckBit] = 1'b0;
    end
    foreach (f[i]) send_byte(f[i]);
  endtask

  // mostly well-formed frames, some stray bytes and broken headers
  task automatic random_bytes(input int unsigned n);
    int unsigned sent;
    int unsigned pick;
    sent = 0;
    while (sent < n) begin
      pick = $urandom_range(0, 99);
      if (pick < 75) begin
        send_frame(1'b0);
        sent += 5;
      end else if (pick < 88) begin
        send_byte(byte_t'($urandom));
        sent += 1;
      end else begin
        send_frame(1'b1);
        sent += 5;
      end
    end
  endtask

  // stop offering until every expected result has come back
  task automatic drain();
    in_valid_i = 1'b0;
    while (sb.samples_due.size() != 0) @(negedge clk_i);
  endtask

  // receiver: random back-pressure, plus a long hold-off on request
  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready_i = 1'b0;
        repeat (HoldLen) @(negedge clk_i);
      end
      out_ready_i = ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // result checker
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      seen = '{status_o, rev_start_o, quality_o, angle_code_o, dist_code_o,
               good_frames_o, bad_windows_o};
      sb.check_sample(seen);
    end
  end

  // watchdog on cycles without any transaction
  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < StallLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet = 0;
      else quiet++;
    end
    $display("TB_ERROR");
    $finish;
  end

  // stimulus sequence
  initial begin
    sb = new;
    sb.clear();
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    rx_byte_i = '0;
    hold_req = 1'b0;
    send_idle_pct = 16;
    recv_idle_pct = 47;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (Directed[i]) send_byte(Directed[i]);
    random_bytes(PhaseBytes);
    drain();

    send_idle_pct = 47;
    recv_idle_pct = 16;
    random_bytes(PhaseBytes);
    drain();

    // no idling; receiver stalls long so the input backs up
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_req = 1'b1;
    random_bytes(PhaseBytes);
    in_valid_i = 1'b0;

    while (sb.samples_due.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.samples_due.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
